// ===== rtl/bounded_indexed_list_defines.svh =====
// assertion macros for the bounded indexed list
`ifndef BOUNDED_INDEXED_LIST_DEFINES_SVH
`define BOUNDED_INDEXED_LIST_DEFINES_SVH

// property checked in the same cycle
`define BIL_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bounded_indexed_list check failed");

// property checked in the next cycle
`define BIL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bounded_indexed_list check failed");

`endif

// ===== rtl/bil_pkg.sv =====
// shared types and constants of the bounded indexed list
package bil_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int CNT_W    = 5;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (OCC_W > POS_W) ? OCC_W : POS_W;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_AT   = 3'd2,
    CMD_DEL_HEAD = 3'd3,
    CMD_DEL_TAIL = 3'd4,
    CMD_DEL_AT   = 3'd5,
    CMD_GET_AT   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADIDX = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CMP_W-1:0] pos;
    data_t            value;
    logic             rd;
  } cell_ctrl_t;

endpackage

// ===== rtl/bil_cell.sv =====
// one list cell: holds an entry and shifts with its neighbors
module bil_cell (
  input  logic                     clk,
  input  logic [bil_pkg::CMP_W-1:0] cell_idx,
  input  bil_pkg::cell_ctrl_t      ctrl,
  input  bil_pkg::data_t           left_val,
  input  bil_pkg::data_t           right_val,
  output bil_pkg::data_t           val_q,
  output bil_pkg::data_t           tap
);
  import bil_pkg::*;

  data_t val_r;
  data_t val_nxt;

  always_comb begin
    val_nxt = val_r;
    unique case (ctrl.op)
      OP_INS: begin
        if (cell_idx > ctrl.pos) begin
          val_nxt = left_val;
        end else if (cell_idx == ctrl.pos) begin
          val_nxt = ctrl.value;
        end
      end
      OP_DEL: begin
        if (cell_idx >= ctrl.pos) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_q = val_r;
  assign tap   = (ctrl.rd && (cell_idx == ctrl.pos)) ? val_r : '0;

endmodule

// ===== rtl/bounded_indexed_list.sv =====
// top level of the bounded indexed list: command decode, occupancy and cell chain
// Ordered list of up to CAPACITY signed 32-bit words kept in a chain of cells.
// A command word (in_cmd, in_position, in_item_value) is taken at a rising edge
// where start is high and busy is low. busy stays low: every command finishes
// in the cycle it is taken, so a new command may follow in every cycle.
// Inserts shift the cells at and above the position up by one, deletes shift
// them down by one, all cells moving in parallel.
// The result word (out_status, out_read_value, out_count) appears in the cycle
// after the command, marked by out_valid for exactly one cycle; the receiver
// cannot stall it. Throughput is one command per cycle.
// out_read_value carries the entry for a good get_at and zero otherwise;
// out_count is the number of entries after the command.
// Reset (rst_n low, synchronous) empties the list and clears out_valid; the
// stored entries are left as they are and are never read before written.
module bounded_indexed_list (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_cmd,
  input  logic [bil_pkg::POS_W-1:0] in_position,
  input  bil_pkg::data_t            in_item_value,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output bil_pkg::data_t            out_read_value,
  output logic [bil_pkg::CNT_W-1:0] out_count
);
  import bil_pkg::*;
  `include "bounded_indexed_list_defines.svh"

  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;
  logic             out_valid_r;
  status_t          status_r;
  status_t          status_nxt;
  data_t            rd_r;
  data_t            rd_nxt;
  logic [CNT_W-1:0] count_r;

  cell_ctrl_t       ctrl;
  cell_op_t         op;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] occ_ext;
  logic             full;
  logic             empty;

  data_t cell_q   [CAPACITY];
  data_t cell_tap [CAPACITY];

  assign busy    = 1'b0;
  assign pos_ext = CMP_W'(in_position);
  assign occ_ext = CMP_W'(occ_r);
  assign full    = (occ_r == OCC_W'(CAPACITY));
  assign empty   = (occ_r == '0);

  // command decode
  always_comb begin
    op         = OP_HOLD;
    ctrl.pos   = '0;
    ctrl.value = in_item_value;
    ctrl.rd    = 1'b0;
    status_nxt = ST_OK;
    unique case (in_cmd)
      CMD_INS_HEAD: begin
        if (full) status_nxt = ST_FULL;
        else op = OP_INS;
      end
      CMD_INS_TAIL: begin
        ctrl.pos = occ_ext;
        if (full) status_nxt = ST_FULL;
        else op = OP_INS;
      end
      CMD_INS_AT: begin
        ctrl.pos = pos_ext;
        if (pos_ext > occ_ext) status_nxt = ST_BADIDX;
        else if (full) status_nxt = ST_FULL;
        else op = OP_INS;
      end
      CMD_DEL_HEAD: begin
        if (empty) status_nxt = ST_EMPTY;
        else op = OP_DEL;
      end
      CMD_DEL_TAIL: begin
        ctrl.pos = occ_ext - CMP_W'(1);
        if (empty) status_nxt = ST_EMPTY;
        else op = OP_DEL;
      end
      CMD_DEL_AT: begin
        ctrl.pos = pos_ext;
        if (empty) status_nxt = ST_EMPTY;
        else if (pos_ext >= occ_ext) status_nxt = ST_BADIDX;
        else op = OP_DEL;
      end
      CMD_GET_AT: begin
        ctrl.pos = pos_ext;
        if (empty) status_nxt = ST_EMPTY;
        else if (pos_ext >= occ_ext) status_nxt = ST_BADIDX;
        else ctrl.rd = start;
      end
      default: status_nxt = ST_OK;
    endcase
    ctrl.op = start ? op : OP_HOLD;
  end

  always_comb begin
    case (ctrl.op)
      OP_INS:  occ_nxt = occ_r + OCC_W'(1);
      OP_DEL:  occ_nxt = occ_r - OCC_W'(1);
      default: occ_nxt = occ_r;
    endcase
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t left_val;
    data_t right_val;
    if (i == 0) begin : g_first
      assign left_val = cell_q[i];
    end else begin : g_left
      assign left_val = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_q[i];
    end else begin : g_right
      assign right_val = cell_q[i+1];
    end
    bil_cell u_cell (
      .clk       (clk),
      .cell_idx  (CMP_W'(i)),
      .ctrl      (ctrl),
      .left_val  (left_val),
      .right_val (right_val),
      .val_q     (cell_q[i]),
      .tap       (cell_tap[i])
    );
  end

  // read bus: only the addressed cell drives a nonzero tap
  always_comb begin
    rd_nxt = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_nxt = rd_nxt | cell_tap[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
      count_r  <= CNT_W'(occ_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_value = rd_r;
  assign out_count      = count_r;

  `BIL_ASSERT_NEXT(a_result_follows, start && rst_n, out_valid)
  `BIL_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= OCC_W'(CAPACITY))
  `BIL_ASSERT_NEXT(a_idle_holds, !start && rst_n, $stable(occ_r))
  `BIL_ASSERT_NOW(a_full_count, out_valid && (out_status == ST_FULL), out_count == CNT_W'(CAPACITY))
  `BIL_ASSERT_NEXT(a_occ_step, rst_n, (occ_r == $past(occ_r)) || (occ_r == $past(occ_r) + OCC_W'(1)) || (occ_r == $past(occ_r) - OCC_W'(1)))

endmodule
